@@ rtl/fcle_pkg.sv @@
// Shared types, constants and the round/saturate function of the fully
// connected layer engine. No dependencies; every other rtl file but fcle_ram imports it.
`default_nettype none

package fcle_pkg;

  // Fixed-point format and field widths
  localparam int VALUE_BITS   = 16;
  localparam int FRAC_BITS    = 12;
  localparam int CMD_BITS     = 3;
  localparam int IDX_BITS     = 5;
  localparam int CNT_BITS     = 6;
  localparam int CFG_IDX_BITS = 2;

  // Default store dimensions
  localparam int MAX_ROWS_DEF = 32;
  localparam int MAX_COLS_DEF = 32;

  // Accumulator: full products plus headroom for up to 63 terms and the bias
  localparam int ACC_W = 2 * VALUE_BITS + 8;

  // Count registers after reset
  localparam logic [CNT_BITS-1:0] CNT_RESET = CNT_BITS'(32);

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW_COUNT = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_COL_COUNT = CFG_IDX_BITS'(1);

  // Command codes
  localparam logic [CMD_BITS-1:0] CMD_WR_WEIGHT = CMD_BITS'(0);
  localparam logic [CMD_BITS-1:0] CMD_WR_BIAS   = CMD_BITS'(1);
  localparam logic [CMD_BITS-1:0] CMD_WR_INPUT  = CMD_BITS'(2);
  localparam logic [CMD_BITS-1:0] CMD_WR_GRAD   = CMD_BITS'(3);
  localparam logic [CMD_BITS-1:0] CMD_FORWARD   = CMD_BITS'(4);
  localparam logic [CMD_BITS-1:0] CMD_IN_GRAD   = CMD_BITS'(5);
  localparam logic [CMD_BITS-1:0] CMD_W_GRAD    = CMD_BITS'(6);
  localparam logic [CMD_BITS-1:0] CMD_B_GRAD    = CMD_BITS'(7);

  // Saturation limits, in result width and in accumulator width
  localparam logic signed [VALUE_BITS-1:0] RES_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] RES_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ACC_RES_MAX =
    {{(ACC_W-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_RES_MIN = ~ACC_RES_MAX;
  localparam logic signed [ACC_W-1:0] HALF_LSB =
    (FRAC_BITS > 0) ? (ACC_W'(1) << (FRAC_BITS - 1)) : '0;

  // Input word
  typedef struct packed {
    logic [CMD_BITS-1:0]          command;
    logic [IDX_BITS-1:0]          row;
    logic [IDX_BITS-1:0]          col;
    logic signed [VALUE_BITS-1:0] value;
  } fcle_in_t;

  // Result word
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] result;
    logic                         saturated;
    logic                         index_error;
  } fcle_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic init;
    logic issue;
    logic finish;
  } fcle_ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic ok;
    logic is_write;
    logic terms_done;
    logic pipe_empty;
  } fcle_sts_t;

  // Rounded and clipped value
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] result;
    logic                         sat;
  } fcle_rnd_t;

  // True for the four store-write commands
  function automatic logic is_write_cmd(input logic [CMD_BITS-1:0] c);
    logic w;
    case (c)
      CMD_WR_WEIGHT, CMD_WR_BIAS, CMD_WR_INPUT, CMD_WR_GRAD: w = 1'b1;
      default: w = 1'b0;
    endcase
    return w;
  endfunction

  // Round half up to FRAC_BITS, then clip to the result range
  function automatic fcle_rnd_t round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] shr;
    fcle_rnd_t               r;
    sum = acc + HALF_LSB;
    shr = sum >>> FRAC_BITS;
    if (shr > ACC_RES_MAX) begin
      r.result = RES_MAX;
      r.sat    = 1'b1;
    end else if (shr < ACC_RES_MIN) begin
      r.result = RES_MIN;
      r.sat    = 1'b1;
    end else begin
      r.result = shr[VALUE_BITS-1:0];
      r.sat    = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/fcle_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for every store of the engine.
`default_nettype none

module fcle_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word and register one read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/fcle_ctrl.sv @@
// Sequencer of the fully connected layer engine: accepts a command and
// steps the datapath through load, multiply-accumulate, drain and finish
// (writes and bad indexes go straight to finish). Depends on fcle_pkg.
`default_nettype none

module fcle_ctrl import fcle_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire fcle_sts_t  sts,
  output logic            busy,
  output fcle_ctrl_t      ctrl
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_INIT   = 3'd2;
  localparam logic [2:0] S_RUN    = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Decode next state and datapath commands
  always_comb begin
    ctrl      = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctrl.accept = 1'b1;
          // writes and bad indexes answer at once
          state_nxt = (sts.ok && !sts.is_write) ? S_LOAD : S_FINISH;
        end
      end
      S_LOAD: begin
        // store reads for the initial value are in flight
        state_nxt = S_INIT;
      end
      S_INIT: begin
        ctrl.init = 1'b1;
        if (!sts.terms_done) begin
          ctrl.issue = 1'b1;
          state_nxt  = S_RUN;
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_RUN: begin
        if (!sts.terms_done) begin
          ctrl.issue = 1'b1;
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts.pipe_empty) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        ctrl.finish = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

@@ rtl/fcle_dp.sv @@
// Datapath of the fully connected layer engine: count registers, the four
// stores, the multiply-accumulate pipeline and the result register.
// Depends on fcle_pkg and fcle_ram.
`default_nettype none

module fcle_dp import fcle_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire fcle_ctrl_t              ctrl,
  output fcle_sts_t                    sts,
  input  wire fcle_in_t                in_data,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CNT_BITS-1:0]     cfg_wdata,
  output logic                         out_strobe,
  output fcle_out_t                    out_data
);

  localparam int RAW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CAW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int WDEPTH = MAX_ROWS * MAX_COLS;
  localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam logic [8:0] ROW_LIM = 9'(MAX_ROWS);
  localparam logic [8:0] COL_LIM = 9'(MAX_COLS);

  logic [CNT_BITS-1:0] row_count_r;
  logic [CNT_BITS-1:0] col_count_r;
  logic [CNT_BITS-1:0] rows_used;
  logic [CNT_BITS-1:0] cols_used;
  logic                row_ok;
  logic                col_ok;
  logic                ok;
  logic [CNT_BITS-1:0] n_nxt;

  logic [CMD_BITS-1:0] cmd_r;
  logic [IDX_BITS-1:0] row_r;
  logic [IDX_BITS-1:0] col_r;
  logic                ok_r;
  logic [CNT_BITS-1:0] n_r;
  logic [CNT_BITS-1:0] k_r;

  logic                  we_weight;
  logic                  we_bias;
  logic                  we_input;
  logic                  we_grad;
  logic [WAW-1:0]        w_waddr;
  logic [WAW-1:0]        w_raddr;
  logic [CAW-1:0]        in_raddr;
  logic [RAW-1:0]        grad_raddr;
  logic [VALUE_BITS-1:0] w_rd;
  logic [VALUE_BITS-1:0] bias_rd;
  logic [VALUE_BITS-1:0] in_rd;
  logic [VALUE_BITS-1:0] grad_rd;

  logic signed [VALUE_BITS-1:0]   op_a;
  logic signed [VALUE_BITS-1:0]   op_b;
  logic signed [2*VALUE_BITS-1:0] prod_r;
  logic                           v1_r;
  logic                           v2_r;
  logic signed [ACC_W-1:0]        init_val;
  logic signed [ACC_W-1:0]        acc_r;
  fcle_rnd_t                      rnd;
  logic                           out_strobe_r;
  fcle_out_t                      out_data_r;

  // Hold the count registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= CNT_RESET;
      col_count_r <= CNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_COUNT: row_count_r <= cfg_wdata;
        REG_COL_COUNT: col_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp counts to the store size
  assign rows_used = ({3'b000, row_count_r} < ROW_LIM) ? row_count_r : ROW_LIM[CNT_BITS-1:0];
  assign cols_used = ({3'b000, col_count_r} < COL_LIM) ? col_count_r : COL_LIM[CNT_BITS-1:0];
  assign row_ok    = ({1'b0, in_data.row} < rows_used);
  assign col_ok    = ({1'b0, in_data.col} < cols_used);

  // Check indexes and pick the term count of the incoming word
  always_comb begin
    case (in_data.command)
      CMD_WR_BIAS, CMD_WR_GRAD, CMD_FORWARD, CMD_B_GRAD: ok = row_ok;
      CMD_WR_INPUT, CMD_IN_GRAD: ok = col_ok;
      default: ok = row_ok && col_ok;
    endcase
    case (in_data.command)
      CMD_FORWARD: n_nxt = cols_used;
      CMD_IN_GRAD: n_nxt = rows_used;
      CMD_W_GRAD:  n_nxt = CNT_BITS'(1);
      default:     n_nxt = '0;
    endcase
  end

  assign sts.ok         = ok;
  assign sts.is_write   = is_write_cmd(in_data.command);
  assign sts.terms_done = (k_r >= n_r);
  assign sts.pipe_empty = !v1_r && !v2_r;

  // Capture the accepted word
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      cmd_r <= in_data.command;
      row_r <= in_data.row;
      col_r <= in_data.col;
      ok_r  <= ok;
      n_r   <= n_nxt;
    end
  end

  // Step the term counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (ctrl.accept) begin
      k_r <= '0;
    end else if (ctrl.issue) begin
      k_r <= k_r + 1'b1;
    end
  end

  // Store writes land at the accept edge
  assign we_weight = ctrl.accept && ok && (in_data.command == CMD_WR_WEIGHT);
  assign we_bias   = ctrl.accept && ok && (in_data.command == CMD_WR_BIAS);
  assign we_input  = ctrl.accept && ok && (in_data.command == CMD_WR_INPUT);
  assign we_grad   = ctrl.accept && ok && (in_data.command == CMD_WR_GRAD);
  assign w_waddr   = WAW'(int'(in_data.row) * MAX_COLS + int'(in_data.col));

  // Walk a weight row for forward, a weight column for input gradient
  assign w_raddr    = (cmd_r == CMD_FORWARD) ? WAW'(int'(row_r) * MAX_COLS + int'(k_r))
                                             : WAW'(int'(k_r) * MAX_COLS + int'(col_r));
  assign in_raddr   = (cmd_r == CMD_FORWARD) ? CAW'(k_r) : CAW'(col_r);
  assign grad_raddr = (cmd_r == CMD_IN_GRAD) ? RAW'(k_r) : RAW'(row_r);

  fcle_ram #(.WIDTH(VALUE_BITS), .DEPTH(WDEPTH)) u_weight (
    .clk   (clk),
    .we    (we_weight),
    .waddr (w_waddr),
    .wdata (in_data.value),
    .raddr (w_raddr),
    .rdata (w_rd)
  );

  fcle_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ROWS)) u_bias (
    .clk   (clk),
    .we    (we_bias),
    .waddr (RAW'(in_data.row)),
    .wdata (in_data.value),
    .raddr (RAW'(row_r)),
    .rdata (bias_rd)
  );

  fcle_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_COLS)) u_input (
    .clk   (clk),
    .we    (we_input),
    .waddr (CAW'(in_data.col)),
    .wdata (in_data.value),
    .raddr (in_raddr),
    .rdata (in_rd)
  );

  fcle_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ROWS)) u_grad (
    .clk   (clk),
    .we    (we_grad),
    .waddr (RAW'(in_data.row)),
    .wdata (in_data.value),
    .raddr (grad_raddr),
    .rdata (grad_rd)
  );

  // Select multiplier operands and the starting accumulator value
  always_comb begin
    op_a = (cmd_r == CMD_W_GRAD)  ? $signed(grad_rd) : $signed(w_rd);
    op_b = (cmd_r == CMD_IN_GRAD) ? $signed(grad_rd) : $signed(in_rd);
    case (cmd_r)
      CMD_FORWARD: init_val = ACC_W'($signed(bias_rd)) <<< FRAC_BITS;
      CMD_B_GRAD:  init_val = ACC_W'($signed(grad_rd)) <<< FRAC_BITS;
      default:     init_val = '0;
    endcase
  end

  // Track words through read and multiply stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ctrl.issue;
      v2_r <= v1_r;
    end
  end

  // Multiply, then accumulate
  always_ff @(posedge clk) begin
    if (v1_r) begin
      prod_r <= op_a * op_b;
    end
    if (ctrl.init) begin
      acc_r <= init_val;
    end else if (v2_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign rnd = round_sat(acc_r);

  // Register the result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= ctrl.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      if (ok_r && !is_write_cmd(cmd_r)) begin
        out_data_r.result    <= rnd.result;
        out_data_r.saturated <= rnd.sat;
      end else begin
        out_data_r.result    <= '0;
        out_data_r.saturated <= 1'b0;
      end
      out_data_r.index_error <= !ok_r;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

`default_nettype wire

@@ rtl/fully_connected_layer_engine_unit.sv @@
// Top level of the fully connected layer engine: controller plus datapath.
// Depends on fcle_pkg, fcle_ctrl, fcle_dp and fcle_ram.
//
// Use: load weights, bias, input and output gradient one element per word
// with the write commands, then issue query commands. A word is taken on a
// rising edge with start high and busy low. Every word yields exactly one
// result word, shown on out_data for one cycle with out_strobe high; the
// receiver cannot hold it off.
// Steps from the accept edge to the strobe cycle:
//   writes and index errors: the finish state, then the registered strobe
//   forward row / input gradient: store reads, then n multiply-accumulates,
//   n = columns / rows in use, one per cycle through the weight store read
//   port, then a drain of the read and multiply stages, finish and strobe
//   weight gradient / bias gradient: the same path with one term / none
// One word is worked on at a time; busy drops in the strobe cycle, so the
// next word may be taken there. Reset (rst_n low, synchronous) sets both
// counts to 32 and idles the sequencer; store contents are unknown until
// written. Count registers are written through cfg_we/cfg_index/cfg_wdata;
// the user must make such writes only while idle; the block has no check.
`default_nettype none

module fully_connected_layer_engine_unit import fcle_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire fcle_in_t                in_data,
  output logic                         out_strobe,
  output fcle_out_t                    out_data,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CNT_BITS-1:0]     cfg_wdata
);

  fcle_ctrl_t ctrl;
  fcle_sts_t  sts;

  fcle_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  fcle_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .sts        (sts),
    .in_data    (in_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/fcle_chk.sv @@
// Port-level checker for the fully connected layer engine, bound to the
// top level. Depends on fcle_pkg.
`default_nettype none

module fcle_chk import fcle_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire fcle_in_t  in_data,
  input wire logic      out_strobe,
  input wire fcle_out_t out_data
);

  // A taken word always makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy low after an accepted word");

  // Writes answer straight from the finish state after the accept
  a_write_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && is_write_cmd(in_data.command) |-> ##2 out_strobe)
    else $error("write word gave no result on time");

  // Result words never come back to back
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("two result words in a row");

  // An index error carries a zero, unclipped result
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.index_error |-> (out_data.result == '0) && !out_data.saturated)
    else $error("index error with nonzero result");

  // A clipped result sits at one end of the range
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.saturated |->
      (out_data.result == RES_MAX) || (out_data.result == RES_MIN))
    else $error("saturated result not at a limit");

endmodule

bind fully_connected_layer_engine_unit fcle_chk u_fcle_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_data    (in_data),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);

`default_nettype wire

@@ test/fcle_result_checker.sv @@
// Result checker for the fully connected layer engine: tracks the stores and
// counts, predicts each result word and compares it with the one that comes out.
// Depends on fcle_pkg for the word types, command codes and register indexes.
`default_nettype none

module fcle_result_checker import fcle_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic                    busy,
  input  wire fcle_in_t                in_data,
  input  wire logic                    out_strobe,
  input  wire fcle_out_t               out_data,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CNT_BITS-1:0]     cfg_wdata,
  output int                           fail_count,
  output int                           pending
);

  typedef struct {
    fcle_in_t  word;
    fcle_out_t want;
  } awaited_t;

  awaited_t awaited_results[$];
  int       fails = 0;

  // Shadow copy of the count registers and the four stores
  logic [CNT_BITS-1:0]          rows_set;
  logic [CNT_BITS-1:0]          cols_set;
  logic signed [VALUE_BITS-1:0] weights [0:MAX_ROWS_DEF*MAX_COLS_DEF-1];
  logic signed [VALUE_BITS-1:0] biases  [0:MAX_ROWS_DEF-1];
  logic signed [VALUE_BITS-1:0] inputs  [0:MAX_COLS_DEF-1];
  logic signed [VALUE_BITS-1:0] grads   [0:MAX_ROWS_DEF-1];

  // Round half up to the result's fraction bits, then clip to its range
  function automatic fcle_out_t round_clip(input longint acc);
    fcle_out_t o;
    longint    q;
    o = '0;
    q = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (q > longint'(RES_MAX)) begin
      o.result    = RES_MAX;
      o.saturated = 1'b1;
    end else if (q < longint'(RES_MIN)) begin
      o.result    = RES_MIN;
      o.saturated = 1'b1;
    end else begin
      o.result = q[VALUE_BITS-1:0];
    end
    return o;
  endfunction

  // Apply one input word to the shadow stores and return its result word
  function automatic fcle_out_t layer_result(input fcle_in_t w);
    fcle_out_t o;
    int        nr;
    int        nc;
    int        r;
    int        c;
    int        k;
    bit        row_ok;
    bit        col_ok;
    bit        ok;
    longint    acc;
    nr = (int'(rows_set) < MAX_ROWS_DEF) ? int'(rows_set) : MAX_ROWS_DEF;
    nc = (int'(cols_set) < MAX_COLS_DEF) ? int'(cols_set) : MAX_COLS_DEF;
    r  = int'(w.row);
    c  = int'(w.col);
    row_ok = r < nr;
    col_ok = c < nc;
    case (w.command)
      CMD_WR_WEIGHT, CMD_W_GRAD: ok = row_ok && col_ok;
      CMD_WR_INPUT, CMD_IN_GRAD: ok = col_ok;
      default:                   ok = row_ok;
    endcase
    o = '0;
    if (ok) begin
      case (w.command)
        CMD_WR_WEIGHT: weights[r*MAX_COLS_DEF + c] = w.value;
        CMD_WR_BIAS:   biases[r] = w.value;
        CMD_WR_INPUT:  inputs[c] = w.value;
        CMD_WR_GRAD:   grads[r] = w.value;
        CMD_FORWARD: begin
          acc = longint'(biases[r]) <<< FRAC_BITS;
          for (k = 0; k < nc; k++)
            acc += longint'(weights[r*MAX_COLS_DEF + k]) * longint'(inputs[k]);
          o = round_clip(acc);
        end
        CMD_IN_GRAD: begin
          acc = 0;
          for (k = 0; k < nr; k++)
            acc += longint'(weights[k*MAX_COLS_DEF + c]) * longint'(grads[k]);
          o = round_clip(acc);
        end
        CMD_W_GRAD: o = round_clip(longint'(grads[r]) * longint'(inputs[c]));
        default:    o.result = grads[r];
      endcase
    end
    o.index_error = !ok;
    return o;
  endfunction

  // Retire result words, then take register writes and accepted words
  always @(posedge clk) begin
    awaited_t  head;
    awaited_t  item;
    if (!rst_n) begin
      rows_set = CNT_RESET;
      cols_set = CNT_RESET;
      awaited_results.delete();
    end else begin
      if (out_strobe) begin
        if (awaited_results.size() == 0) begin
          fails++;
          $display("%0t: result word %h arrived with none expected", $time, out_data);
        end else begin
          head = awaited_results.pop_front();
          if (out_data.result !== head.want.result ||
              out_data.saturated !== head.want.saturated ||
              out_data.index_error !== head.want.index_error) begin
            fails++;
            $write("%0t: command %0d row %0d col %0d: ",
                   $time, head.word.command, head.word.row, head.word.col);
            $display("expected result %h sat %b err %b, actual result %h sat %b err %b",
                     head.want.result, head.want.saturated, head.want.index_error,
                     out_data.result, out_data.saturated, out_data.index_error);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ROW_COUNT: rows_set = cfg_wdata;
          REG_COL_COUNT: cols_set = cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) begin
        item.word = in_data;
        item.want = layer_result(in_data);
        awaited_results.push_back(item);
      end
    end
    pending    <= awaited_results.size();
    fail_count <= fails;
  end

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Top of the fully connected layer engine testbench: clock, reset, register
// setup and command stimulus; fcle_result_checker does the comparing.
// Depends on fcle_pkg, fully_connected_layer_engine_unit and fcle_result_checker.
`default_nettype none

module testbench;
  import fcle_pkg::*;

  localparam int WORD_TARGET   = 1950;
  localparam int PHASE_WORDS   = 240;
  localparam int SETTLE_CYCLES = 45;
  localparam int PHASE_COUNT   = 8;

  // Register indexes that hold no register
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = CFG_IDX_BITS'(3);

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    start     = 1'b0;
  logic                    busy;
  fcle_in_t                in_data   = '0;
  logic                    out_strobe;
  fcle_out_t               out_data;
  logic                    cfg_we    = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CNT_BITS-1:0]     cfg_wdata = '0;
  int                      fail_count;
  int                      pending;

  // Count settings of the random phases, extremes among them
  int phase_rows [PHASE_COUNT] = '{32, 1, 32, 0, 63, 12, 5, 17};
  int phase_cols [PHASE_COUNT] = '{32, 32, 1, 9, 63, 0, 7, 30};

  // Counts as last written and entries written in range so far
  int rows_cfg = 32;
  int cols_cfg = 32;
  bit weight_loaded [0:MAX_ROWS_DEF*MAX_COLS_DEF-1];
  bit bias_loaded   [0:MAX_ROWS_DEF-1];
  bit input_loaded  [0:MAX_COLS_DEF-1];
  bit grad_loaded   [0:MAX_ROWS_DEF-1];
  int words_issued = 0;
  int burst_left   = 0;

  fully_connected_layer_engine_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  fcle_result_checker result_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int rows_in_use();
    return (rows_cfg < MAX_ROWS_DEF) ? rows_cfg : MAX_ROWS_DEF;
  endfunction

  function automatic int cols_in_use();
    return (cols_cfg < MAX_COLS_DEF) ? cols_cfg : MAX_COLS_DEF;
  endfunction

  // Mix of extremes, full-range values and small values that rarely saturate
  function automatic logic [VALUE_BITS-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return RES_MAX;
      1:       return RES_MIN;
      2:       return '0;
      3, 4, 5: return VALUE_BITS'($urandom);
      6, 7:    return VALUE_BITS'(int'($urandom_range(0, 8191)) - 4096);
      default: return VALUE_BITS'(int'($urandom_range(0, 1023)) - 512);
    endcase
  endfunction

  // Mostly an index in range, sometimes any index
  function automatic int pick_index(input int limit);
    if (limit > 0 && $urandom_range(0, 99) < 85)
      return $urandom_range(0, limit - 1);
    return $urandom_range(0, 31);
  endfunction

  function automatic int gap_cycles();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(12, 45);
      1, 2, 3: return 1;
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  // Offer one word, hold it until taken, then pace the next one
  task automatic issue_word(input logic [CMD_BITS-1:0] cmd, input int r, input int c,
                            input logic [VALUE_BITS-1:0] v);
    fcle_in_t w;
    bit       row_ok;
    bit       col_ok;
    w.command = cmd;
    w.row     = IDX_BITS'(r);
    w.col     = IDX_BITS'(c);
    w.value   = v;
    start   <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_issued++;
    // note which entries are now safe to read
    row_ok = r < rows_in_use();
    col_ok = c < cols_in_use();
    case (cmd)
      CMD_WR_WEIGHT: if (row_ok && col_ok) weight_loaded[r*MAX_COLS_DEF + c] = 1'b1;
      CMD_WR_BIAS:   if (row_ok) bias_loaded[r] = 1'b1;
      CMD_WR_INPUT:  if (col_ok) input_loaded[c] = 1'b1;
      CMD_WR_GRAD:   if (row_ok) grad_loaded[r] = 1'b1;
      default: ;
    endcase
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat (gap_cycles()) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90)
                                               : $urandom_range(0, 10);
    end
  endtask

  // Write every entry a query would read that has not been written yet
  task automatic load_for_query(input logic [CMD_BITS-1:0] cmd, input int r, input int c);
    int nr;
    int nc;
    int k;
    nr = rows_in_use();
    nc = cols_in_use();
    case (cmd)
      CMD_FORWARD: if (r < nr) begin
        if (!bias_loaded[r]) issue_word(CMD_WR_BIAS, r, $urandom_range(0, 31), rand_value());
        for (k = 0; k < nc; k++) begin
          if (!weight_loaded[r*MAX_COLS_DEF + k])
            issue_word(CMD_WR_WEIGHT, r, k, rand_value());
          if (!input_loaded[k])
            issue_word(CMD_WR_INPUT, $urandom_range(0, 31), k, rand_value());
        end
      end
      CMD_IN_GRAD: if (c < nc) begin
        for (k = 0; k < nr; k++) begin
          if (!weight_loaded[k*MAX_COLS_DEF + c])
            issue_word(CMD_WR_WEIGHT, k, c, rand_value());
          if (!grad_loaded[k])
            issue_word(CMD_WR_GRAD, k, $urandom_range(0, 31), rand_value());
        end
      end
      CMD_W_GRAD: if (r < nr && c < nc) begin
        if (!grad_loaded[r]) issue_word(CMD_WR_GRAD, r, $urandom_range(0, 31), rand_value());
        if (!input_loaded[c]) issue_word(CMD_WR_INPUT, $urandom_range(0, 31), c, rand_value());
      end
      CMD_B_GRAD: if (r < nr) begin
        if (!grad_loaded[r]) issue_word(CMD_WR_GRAD, r, $urandom_range(0, 31), rand_value());
      end
      default: ;
    endcase
  endtask

  // Drop start and wait until every result word has come back
  task automatic go_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write both counts, then an index that holds no register
  task automatic set_counts(input int rows, input int cols);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROW_COUNT;
    cfg_wdata <= CNT_BITS'(rows);
    @(posedge clk);
    cfg_index <= REG_COL_COUNT;
    cfg_wdata <= CNT_BITS'(cols);
    @(posedge clk);
    cfg_index <= $urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI;
    cfg_wdata <= CNT_BITS'($urandom_range(0, 63));
    @(posedge clk);
    cfg_we   <= 1'b0;
    rows_cfg = rows & 63;
    cols_cfg = cols & 63;
    @(posedge clk);
  endtask

  initial begin
    logic [CMD_BITS-1:0] cmd;
    int                  r;
    int                  c;
    int                  phase;
    int                  next_phase;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: smallest sizes, saturation both ways, index errors, rounding ties
    set_counts(1, 1);
    issue_word(CMD_WR_WEIGHT, 0, 0, RES_MAX);
    issue_word(CMD_WR_INPUT, 31, 0, RES_MAX);
    issue_word(CMD_WR_BIAS, 0, 31, RES_MIN);
    issue_word(CMD_WR_GRAD, 0, 17, RES_MIN);
    issue_word(CMD_FORWARD, 0, 0, '1);
    issue_word(CMD_IN_GRAD, 9, 0, '1);
    issue_word(CMD_W_GRAD, 0, 0, '0);
    issue_word(CMD_B_GRAD, 0, 0, '0);
    issue_word(CMD_FORWARD, 1, 0, '0);
    issue_word(CMD_IN_GRAD, 0, 31, '0);
    issue_word(CMD_W_GRAD, 0, 1, '0);
    issue_word(CMD_B_GRAD, 31, 0, '0);
    issue_word(CMD_WR_WEIGHT, 31, 31, 16'h1234);
    issue_word(CMD_WR_INPUT, 0, 1, 16'h0111);
    issue_word(CMD_WR_BIAS, 1, 0, 16'h0222);
    issue_word(CMD_WR_GRAD, 0, 0, 16'h0001);
    issue_word(CMD_WR_INPUT, 0, 0, 16'h0800);
    issue_word(CMD_W_GRAD, 0, 0, '0);
    issue_word(CMD_WR_GRAD, 0, 0, 16'hFFFF);
    issue_word(CMD_W_GRAD, 0, 0, '0);
    issue_word(CMD_FORWARD, 0, 0, '0);
    issue_word(CMD_B_GRAD, 0, 0, '0);

    // Random: phases of count settings, queries preceded by the loads they need
    phase      = 0;
    next_phase = words_issued;
    while (words_issued < WORD_TARGET) begin
      if (words_issued >= next_phase) begin
        go_idle();
        if (phase < PHASE_COUNT)
          set_counts(phase_rows[phase], phase_cols[phase]);
        else if ($urandom_range(0, 3) == 0)
          set_counts($urandom_range(0, 63), $urandom_range(0, 63));
        else
          set_counts($urandom_range(1, 32), $urandom_range(1, 32));
        phase++;
        next_phase = words_issued + PHASE_WORDS;
      end
      cmd = CMD_BITS'($urandom_range(0, 7));
      r   = pick_index(rows_in_use());
      c   = pick_index(cols_in_use());
      load_for_query(cmd, r, c);
      issue_word(cmd, r, c, rand_value());
    end

    go_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire

@@ fully_connected_layer_engine_unit.f @@
rtl/fcle_pkg.sv
rtl/fcle_ram.sv
rtl/fcle_ctrl.sv
rtl/fcle_dp.sv
rtl/fully_connected_layer_engine_unit.sv
rtl/fcle_chk.sv
test/fcle_result_checker.sv
test/testbench.sv
